[rtl/core/uhc_pkg.sv]
// uhc_pkg: shared types, field offsets and constants for the ustar header checker.
// No dependencies.
`timescale 1ns / 1ps

package uhc_pkg;

  localparam int unsigned PosW   = 9;
  localparam int unsigned SumW   = 17;
  localparam int unsigned OctW   = 36;
  localparam int unsigned ModeW  = 24;
  localparam int unsigned CsumW  = 24;
  localparam int unsigned NameW  = 7;
  localparam int unsigned PfxW   = 8;
  localparam int unsigned LimitW = 9;

  localparam logic [PosW-1:0] NameEnd   = 9'd100;
  localparam logic [PosW-1:0] ModeLo    = 9'd100;
  localparam logic [PosW-1:0] ModeHi    = 9'd107;
  localparam logic [PosW-1:0] SizeLo    = 9'd124;
  localparam logic [PosW-1:0] SizeHi    = 9'd135;
  localparam logic [PosW-1:0] MtimeLo   = 9'd136;
  localparam logic [PosW-1:0] MtimeHi   = 9'd147;
  localparam logic [PosW-1:0] CsumLo    = 9'd148;
  localparam logic [PosW-1:0] CsumHi    = 9'd155;
  localparam logic [PosW-1:0] TypePos   = 9'd156;
  localparam logic [PosW-1:0] MagicLo   = 9'd257;
  localparam logic [PosW-1:0] MagicVer  = 9'd262;
  localparam logic [PosW-1:0] PfxLo     = 9'd345;
  localparam logic [PosW-1:0] PfxEnd    = 9'd500;
  localparam logic [PosW-1:0] LastPos   = 9'd511;

  localparam logic [7:0] AsciiSpace = 8'h20;
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiSeven = 8'h37;
  localparam logic [7:0] AsciiNul   = 8'h00;

  localparam logic [LimitW-1:0] PathLimitReset = 9'd256;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PATH_LONG  = 3'd1,
    ST_BAD_SUM    = 3'd2,
    ST_BAD_MAGIC  = 3'd3,
    ST_BAD_NUMBER = 3'd4,
    ST_EMPTY_NAME = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OCT_LEAD   = 2'd0,
    OCT_DIGITS = 2'd1,
    OCT_TRAIL  = 2'd2
  } oct_phase_e;

  typedef struct packed {
    logic [OctW-1:0] acc;
    logic            good;
  } oct_res_t;

  function automatic logic [7:0] ustar_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h75;  // u
      3'd1:    c = 8'h73;  // s
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h61;  // a
      3'd4:    c = 8'h72;  // r
      default: c = AsciiNul;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/uhc_octal_field.sv]
// uhc_octal_field: octal number field parser with its own accumulator and phase.
// Depends on uhc_pkg.
`timescale 1ns / 1ps

module uhc_octal_field import uhc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       first_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  output oct_res_t   res_o
);

  logic [OctW-1:0] acc_q, acc_d, acc_b;
  oct_phase_e      phase_q, phase_d, phase_b;
  logic            digit_q, digit_d, digit_b;
  logic            err_q, err_d, err_b;
  logic            is_end, is_digit;

  assign is_end   = (byte_i == AsciiNul) || (byte_i == AsciiSpace);
  assign is_digit = (byte_i >= AsciiZero) && (byte_i <= AsciiSeven);

  always_comb begin
    acc_b   = first_i ? '0 : acc_q;
    phase_b = first_i ? OCT_LEAD : phase_q;
    digit_b = first_i ? 1'b0 : digit_q;
    err_b   = first_i ? byte_i[7] : err_q;

    acc_d   = acc_b;
    phase_d = phase_b;
    digit_d = digit_b;
    err_d   = err_b;

    unique case (phase_b)
      OCT_LEAD, OCT_DIGITS: begin
        if (phase_b == OCT_LEAD && byte_i == AsciiSpace) begin
          phase_d = OCT_LEAD;
        end else if (is_end) begin
          phase_d = OCT_TRAIL;
        end else if (!is_digit) begin
          phase_d = OCT_DIGITS;
          err_d   = 1'b1;
        end else begin
          phase_d = OCT_DIGITS;
          acc_d   = {acc_b[OctW-4:0], byte_i[2:0]};
          digit_d = 1'b1;
        end
      end
      OCT_TRAIL: begin
        if (!is_end) err_d = 1'b1;
      end
      default: begin
        err_d = 1'b1;
      end
    endcase
  end

  assign res_o.acc  = acc_d;
  assign res_o.good = digit_d && !err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      phase_q <= OCT_LEAD;
      digit_q <= 1'b0;
      err_q   <= 1'b0;
    end else if (clear_i) begin
      acc_q   <= '0;
      phase_q <= OCT_LEAD;
      digit_q <= 1'b0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      acc_q   <= acc_d;
      phase_q <= phase_d;
      digit_q <= digit_d;
      err_q   <= err_d;
    end
  end

endmodule

[rtl/core/ustar_header_checker.sv]
// ustar_header_checker: top level, byte stream checker for 512-byte ustar headers.
// Depends on uhc_pkg and uhc_octal_field.
`timescale 1ns / 1ps

// Header bytes enter one beat per cycle while in_stall_o is low, offset 0
// first; the block counts the offset itself and gives one result beat after
// every 512th input beat. Each beat passes an input register and the per-byte
// field logic; a header's result is registered as its last byte leaves the
// input register. The result register holds while out_stall_i is high; input
// beats flow until the next header's last byte needs that register. The user
// writes path_limit via the cfg port only between headers; it is not enforced.
module ustar_header_checker import uhc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LimitW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        header_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [ModeW-1:0]  file_mode_o,
  output logic [OctW-1:0]   file_size_o,
  output logic [OctW-1:0]   mod_time_o,
  output logic [7:0]        entry_type_o,
  output logic [NameW-1:0]  name_len_o,
  output logic [PfxW-1:0]   prefix_len_o,
  output logic [8:0]        joined_len_o,
  output logic              is_ustar_o
);

  logic [LimitW-1:0] limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= PathLimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last, s1_adv, in_take, out_take;
  logic       out_valid_q;

  logic [PosW-1:0] pos_q, pos_d;

  assign s1_last    = (pos_q == LastPos);
  assign out_take   = out_valid_q && !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_last || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) s1_byte_q <= header_byte_i;
  end

  // per-header state
  logic [SumW-1:0]  sum_q, sum_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic [OctW-1:0]  size_q, size_d;
  logic [OctW-1:0]  mtime_q, mtime_d;
  logic [CsumW-1:0] csum_q, csum_d;
  logic [3:0]       fok_q, fok_d;
  logic [1:0]       magic_q, magic_d;
  logic [NameW-1:0] name_q, name_d;
  logic [PfxW-1:0]  pfx_q, pfx_d;
  logic [1:0]       ldone_q, ldone_d;
  logic [7:0]       type_q, type_d;

  logic       in_mode, in_size, in_mtime, in_csum, in_oct, oct_first;
  logic [8:0] moff;
  oct_res_t   oct_res;
  logic [7:0] b;

  assign b         = s1_byte_q;
  assign in_mode   = (pos_q >= ModeLo) && (pos_q <= ModeHi);
  assign in_size   = (pos_q >= SizeLo) && (pos_q <= SizeHi);
  assign in_mtime  = (pos_q >= MtimeLo) && (pos_q <= MtimeHi);
  assign in_csum   = (pos_q >= CsumLo) && (pos_q <= CsumHi);
  assign in_oct    = in_mode || in_size || in_mtime || in_csum;
  assign oct_first = (pos_q == ModeLo) || (pos_q == SizeLo) ||
                     (pos_q == MtimeLo) || (pos_q == CsumLo);
  assign moff      = pos_q - MagicLo;

  uhc_octal_field u_oct (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_adv && in_oct),
    .first_i (oct_first),
    .clear_i (s1_adv && s1_last),
    .byte_i  (b),
    .res_o   (oct_res)
  );

  always_comb begin
    pos_d   = pos_q + 9'd1;
    sum_d   = sum_q + {9'd0, (in_csum ? AsciiSpace : b)};
    mode_d  = mode_q;
    size_d  = size_q;
    mtime_d = mtime_q;
    csum_d  = csum_q;
    fok_d   = fok_q;
    magic_d = magic_q;
    name_d  = name_q;
    pfx_d   = pfx_q;
    ldone_d = ldone_q;
    type_d  = type_q;

    if (pos_q < NameEnd && !ldone_q[0]) begin
      if (b == AsciiNul) ldone_d[0] = 1'b1;
      else               name_d     = name_q + 7'd1;
    end
    if (pos_q >= PfxLo && pos_q < PfxEnd && !ldone_q[1]) begin
      if (b == AsciiNul) ldone_d[1] = 1'b1;
      else               pfx_d      = pfx_q + 8'd1;
    end
    if (pos_q >= MagicLo && pos_q <= MagicVer) begin
      if (pos_q < MagicVer && b != ustar_char(moff[2:0])) magic_d[0] = 1'b0;
      if (b != AsciiNul) magic_d[1] = 1'b0;
    end
    if (pos_q == TypePos) type_d = b;

    if (oct_res.good) begin
      if (pos_q == ModeHi) begin
        mode_d   = oct_res.acc[ModeW-1:0];
        fok_d[0] = 1'b1;
      end
      if (pos_q == SizeHi) begin
        size_d   = oct_res.acc;
        fok_d[1] = 1'b1;
      end
      if (pos_q == MtimeHi) begin
        mtime_d  = oct_res.acc;
        fok_d[2] = 1'b1;
      end
      if (pos_q == CsumHi) begin
        csum_d   = oct_res.acc[CsumW-1:0];
        fok_d[3] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_q   <= '0;
      mode_q  <= '0;
      size_q  <= '0;
      mtime_q <= '0;
      csum_q  <= '0;
      fok_q   <= '0;
      magic_q <= 2'b11;
      name_q  <= '0;
      pfx_q   <= '0;
      ldone_q <= '0;
      type_q  <= '0;
    end else if (s1_adv) begin
      if (s1_last) begin
        pos_q   <= '0;
        sum_q   <= '0;
        mode_q  <= '0;
        size_q  <= '0;
        mtime_q <= '0;
        csum_q  <= '0;
        fok_q   <= '0;
        magic_q <= 2'b11;
        name_q  <= '0;
        pfx_q   <= '0;
        ldone_q <= '0;
        type_q  <= '0;
      end else begin
        pos_q   <= pos_d;
        sum_q   <= sum_d;
        mode_q  <= mode_d;
        size_q  <= size_d;
        mtime_q <= mtime_d;
        csum_q  <= csum_d;
        fok_q   <= fok_d;
        magic_q <= magic_d;
        name_q  <= name_d;
        pfx_q   <= pfx_d;
        ldone_q <= ldone_d;
        type_q  <= type_d;
      end
    end
  end

  // result of a finished header
  logic            ustar;
  logic [PfxW-1:0] plen;
  logic [8:0]      joined;
  status_e         status;
  logic            ok;

  assign ustar  = magic_d[0];
  assign plen   = ustar ? pfx_d : '0;
  assign joined = {1'b0, plen} + {8'd0, (plen != '0)} + {2'd0, name_d};

  always_comb begin
    priority if (!fok_d[3] || csum_d != {7'd0, sum_d}) begin
      status = ST_BAD_SUM;
    end else if (!ustar && !magic_d[1]) begin
      status = ST_BAD_MAGIC;
    end else if (name_d == '0) begin
      status = ST_EMPTY_NAME;
    end else if (joined >= limit_q) begin
      status = ST_PATH_LONG;
    end else if (fok_d[2:0] != 3'b111) begin
      status = ST_BAD_NUMBER;
    end else begin
      status = ST_OK;
    end
  end

  assign ok = (status == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last) begin
      status_o     <= status;
      file_mode_o  <= ok ? mode_d : '0;
      file_size_o  <= ok ? size_d : '0;
      mod_time_o   <= ok ? mtime_d : '0;
      entry_type_o <= (type_d == AsciiNul) ? AsciiZero : type_d;
      name_len_o   <= name_d;
      prefix_len_o <= plen;
      joined_len_o <= joined;
      is_ustar_o   <= ustar;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
